// File: rtl/outstanding_command_tracker_top_macros.svh
// Assertion macros used by the checker file of the tracker.
`ifndef OUTSTANDING_COMMAND_TRACKER_TOP_MACROS_SVH
`define OUTSTANDING_COMMAND_TRACKER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OCT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tracker assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define OCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tracker assertion failed");

`endif

// File: rtl/oct_pkg.sv
package oct_pkg;

   localparam int LANES  = 16;
   localparam int LANE_W = 4;

   typedef enum logic [1:0] {
      OP_REGISTER = 2'd0,
      OP_RESPONSE = 2'd1,
      OP_QUERY    = 2'd2,
      OP_FAIL     = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_INACTIVE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_EXEC   = 2'd1,
      S_SEARCH = 2'd2
   } state_type;

   typedef struct packed {
      logic set;
      logic clear;
   } slot_cmd_type;

   typedef struct packed {
      logic              found;
      logic [LANE_W-1:0] offset;
   } search_result_type;

endpackage

// File: rtl/outstanding_command_tracker_top.sv
// Response, query and fail items: result registered in S_EXEC; new items wait for S_IDLE.
// Register items: the free-slot search scans 16 slots per cycle, group by group from group 0,
// and takes the lowest free slot of the first group that has one, else reports ST_FULL.
// A stalled result holds the block until the output register can be loaded.
// Synchronous reset clears all active bits at once; counts are used only for active slots.
module outstanding_command_tracker_top #(
   parameter int TAG_SLOTS  = 64,
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [5:0]  req_tag,
   input  logic [15:0] req_expected_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_assigned_tag,
   output logic        rsp_completed,
   output logic        rsp_finished
);
   import oct_pkg::*;

   localparam int IDX_W  = $clog2(TAG_SLOTS);
   localparam int GROUPS = (TAG_SLOTS + LANES - 1) / LANES;
   localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;

   state_type             state_ff, state_in;
   func_type              func_ff;
   logic [5:0]            tag_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [GRP_W-1:0]      group_ff, group_in;

   logic                  rsp_valid_ff;
   status_type            rsp_status_ff, rsp_status_in;
   logic [5:0]            rsp_assigned_tag_ff, rsp_assigned_tag_in;
   logic                  rsp_completed_ff, rsp_completed_in;
   logic                  rsp_finished_ff, rsp_finished_in;
   logic                  out_load;

   logic                  accept;
   logic                  out_free;
   logic                  tag_ok;
   logic                  live;
   logic                  last_group;
   logic                  search_done;
   logic [IDX_W-1:0]      look_index;
   logic [IDX_W-1:0]      slot;
   logic [COUNT_BITS-1:0] remaining;

   slot_cmd_type          cmd;
   logic [IDX_W-1:0]      cmd_index;
   logic                  look_active;
   search_result_type     search;

   logic                  wr_en;
   logic [COUNT_BITS-1:0] wr_data;
   logic [COUNT_BITS-1:0] rd_data;

   assign req_stall   = (state_ff != S_IDLE);
   assign accept      = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign tag_ok      = (32'(tag_ff) < TAG_SLOTS);
   assign look_index  = IDX_W'(tag_ff);
   assign live        = tag_ok && look_active;
   assign last_group  = (group_ff == GRP_W'(GROUPS - 1));
   assign search_done = search.found || last_group;
   assign slot        = IDX_W'({group_ff, search.offset});
   assign remaining   = rd_data - COUNT_BITS'(1);

   oct_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (TAG_SLOTS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cmd_index),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (IDX_W'(req_tag)),
      .rd_data (rd_data)
   );

   oct_slot_map #(
      .TAG_SLOTS (TAG_SLOTS),
      .GRP_W     (GRP_W)
   ) u_slot_map (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cmd_index   (cmd_index),
      .look_index  (look_index),
      .look_active (look_active),
      .group       (group_ff),
      .search      (search)
   );

   always_comb begin
      state_in = state_ff;
      group_in = group_ff;
      case (state_ff)
         S_IDLE: begin
            group_in = '0;
            if (accept) begin
               if (func_type'(req_func) == OP_REGISTER) begin
                  state_in = S_SEARCH;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_SEARCH: begin
            if (search_done) begin
               if (out_free) begin
                  state_in = S_IDLE;
               end
            end else begin
               group_in = group_ff + GRP_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd                 = '0;
      cmd_index           = look_index;
      wr_en               = 1'b0;
      wr_data             = count_ff;
      out_load            = 1'b0;
      rsp_status_in       = ST_OK;
      rsp_assigned_tag_in = '0;
      rsp_completed_in    = 1'b0;
      rsp_finished_in     = 1'b0;
      case (state_ff)
         S_EXEC: begin
            out_load = out_free;
            case (func_ff)
               OP_RESPONSE: begin
                  if (!live) begin
                     rsp_status_in = ST_INACTIVE;
                  end else begin
                     wr_en   = out_free;
                     wr_data = remaining;
                     if (remaining == '0) begin
                        cmd.clear        = out_free;
                        rsp_completed_in = 1'b1;
                     end
                  end
               end
               OP_QUERY: begin
                  rsp_finished_in = !live;
               end
               OP_FAIL: begin
                  if (!live) begin
                     rsp_status_in = ST_INACTIVE;
                  end else begin
                     cmd.clear = out_free;
                  end
               end
               default: begin
                  rsp_status_in = ST_OK;
               end
            endcase
         end
         S_SEARCH: begin
            cmd_index = slot;
            out_load  = out_free && search_done;
            if (!search.found) begin
               rsp_status_in = ST_FULL;
            end else begin
               rsp_assigned_tag_in = 6'(slot);
               if (count_ff == '0) begin
                  rsp_completed_in = 1'b1;
               end else begin
                  cmd.set = out_load;
                  wr_en   = out_load;
               end
            end
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         group_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         group_ff <= group_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= func_type'(req_func);
         tag_ff   <= req_tag;
         count_ff <= COUNT_BITS'(req_expected_count);
      end
      if (out_load) begin
         rsp_status_ff       <= rsp_status_in;
         rsp_assigned_tag_ff <= rsp_assigned_tag_in;
         rsp_completed_ff    <= rsp_completed_in;
         rsp_finished_ff     <= rsp_finished_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_assigned_tag = rsp_assigned_tag_ff;
   assign rsp_completed    = rsp_completed_ff;
   assign rsp_finished     = rsp_finished_ff;

endmodule

// File: rtl/oct_ram.sv
module oct_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/oct_slot_map.sv
module oct_slot_map #(
   parameter int TAG_SLOTS = 64,
   parameter int GRP_W     = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   input  oct_pkg::slot_cmd_type            cmd,
   input  logic [$clog2(TAG_SLOTS)-1:0]     cmd_index,
   input  logic [$clog2(TAG_SLOTS)-1:0]     look_index,
   output logic                             look_active,
   input  logic [GRP_W-1:0]                 group,
   output oct_pkg::search_result_type       search
);
   import oct_pkg::*;

   localparam int GROUPS = (TAG_SLOTS + LANES - 1) / LANES;

   logic [TAG_SLOTS-1:0]     active_ff;
   logic [TAG_SLOTS-1:0]     active_in;
   logic [GROUPS*LANES-1:0]  padded;
   logic [LANES-1:0]         lane_bits;

   always_comb begin
      active_in = active_ff;
      if (cmd.set) begin
         active_in[cmd_index] = 1'b1;
      end
      if (cmd.clear) begin
         active_in[cmd_index] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else begin
         active_ff <= active_in;
      end
   end

   assign look_active = active_ff[look_index];

   // Slots past the end of the table look busy so the search never picks them.
   always_comb begin
      padded = '1;
      padded[TAG_SLOTS-1:0] = active_ff;
   end

   assign lane_bits = padded[group*LANES +: LANES];

   always_comb begin
      search = '0;
      for (int k = LANES - 1; k >= 0; k--) begin
         if (!lane_bits[k]) begin
            search.found  = 1'b1;
            search.offset = LANE_W'(k);
         end
      end
   end

endmodule

// File: rtl/oct_checker.sv
`include "outstanding_command_tracker_top_macros.svh"

module oct_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_status,
   input logic [5:0] rsp_assigned_tag,
   input logic       rsp_completed,
   input logic       rsp_finished
);
   import oct_pkg::*;

   `OCT_ASSERT_NEXT(a_one_item_at_a_time, clock, reset, req_valid && !req_stall, req_stall)
   `OCT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_assigned_tag))
   `OCT_ASSERT_SAME(a_full_clean, clock, reset, rsp_valid && rsp_status == ST_FULL, rsp_assigned_tag == 6'd0 && !rsp_completed && !rsp_finished)
   `OCT_ASSERT_SAME(a_finished_query, clock, reset, rsp_valid && rsp_finished, rsp_status == ST_OK && !rsp_completed && rsp_assigned_tag == 6'd0)
   `OCT_ASSERT_SAME(a_inactive_clean, clock, reset, rsp_valid && rsp_status == ST_INACTIVE, !rsp_completed && !rsp_finished)

endmodule

bind outstanding_command_tracker_top oct_checker u_oct_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_assigned_tag (rsp_assigned_tag),
   .rsp_completed    (rsp_completed),
   .rsp_finished     (rsp_finished)
);
